>>> rtl/core/bfs_pkg.sv
// ---------------------------------------------------------------------------
// bfs_pkg : shared types and constants for the bitonic float sorter
// Sort order key, pad values, sequencer state and register map.
// ---------------------------------------------------------------------------
package bfs_pkg;

  localparam logic [31:0] PAD_POS_MAX = 32'h7F7F_FFFF;
  localparam logic [31:0] PAD_NEG_MAX = 32'hFF7F_FFFF;
  localparam int unsigned MIN_ROW     = 8;
  localparam logic [0:0]  REG_ASCENDING = 1'b0;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_CMP,
    ST_WRITE,
    ST_OUT
  } state_t;

  // monotone key: -0 sits just below +0
  function automatic logic [31:0] order_key(input logic [31:0] bits);
    order_key = bits[31] ? ~bits : (bits | 32'h8000_0000);
  endfunction

endpackage

>>> rtl/core/bitonic_float_sorter.sv
// ---------------------------------------------------------------------------
// bitonic_float_sorter : row sorter for IEEE single-precision values
// Loads a row, pads it to a power of two (at least 8) and sorts it with a
// bitonic compare-exchange network held in a two-port RAM, then streams it.
// ---------------------------------------------------------------------------
// Channel   Dir  Transaction
// s_axis    in   tdata = value[31:0]; tlast = last
// m_axis    out  tdata = sorted_value[31:0]; tlast = final_res; tuser = overflow
// apb       in   0x0 : ascending (bit 0)
//
// Loading accepts one value per cycle. After tlast the sequencer walks every
// compare-exchange pair of the network through read, compare and write-back
// states, P/2 pairs per pass, log2(P)(log2(P)+1)/2 passes. Pad entries
// are not preloaded: an address at or beyond the row length reads as the pad
// value until the network first writes it back (one flag per entry). Output
// reads one entry at a time into a skid register and issues no new read while
// one is in flight; m_axis stalls hold the result there. No new row is taken
// until the last result leaves.
// Reset (rst, synchronous) clears the counters and sets ascending to 1.
// ---------------------------------------------------------------------------
module bitonic_float_sorter
  import bfs_pkg::*;
#(
  parameter int ROW_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser,   // [0] overflow
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = $clog2(ROW_CAPACITY);
  localparam int CW    = AW + 1;
  localparam int DEPTH = 1 << AW;   // padded row can reach the next power of two

  state_t state, state_next;

  logic          ascending;
  logic [CW-1:0] fill_count;
  logic          overflow_seen;
  logic [CW-1:0] psize;        // padded size
  logic [CW-1:0] k, j, i;      // network indices, i walks low element
  logic [CW-1:0] l;
  logic [CW-1:0] out_idx;
  logic [31:0]   va, vb, wa, wb;
  logic          swap;
  logic          pad_a, pad_b;
  logic          last_pair;
  logic [DEPTH-1:0] written;   // entries written back by the network

  // RAM ports
  logic          we_a, we_b;
  logic [AW-1:0] addr_a, addr_b;
  logic [31:0]   wdata_a, wdata_b, rdata_a, rdata_b;

  // output skid
  logic          ob_valid;
  logic [31:0]   ob_data;
  logic          ob_last;

  logic [31:0] pad_val;
  assign pad_val = ascending ? PAD_POS_MAX : PAD_NEG_MAX;

  bfs_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk, .we_a, .addr_a, .wdata_a, .rdata_a, .we_b, .addr_b, .wdata_b, .rdata_b
  );

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ASCENDING) ? {31'd0, ascending} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      ascending <= 1'b1;
    end else if (psel && penable && pwrite && paddr == REG_ASCENDING) begin
      ascending <= pwdata[0];
    end
  end

  assign l = i ^ j;

  // next pair: skip i whose partner is below it
  logic [CW-1:0] i_step;
  always_comb begin
    i_step = i + CW'(1);
    if ((i_step & j) != '0) begin
      i_step = i_step + j;
    end
  end
  assign last_pair = (i_step >= psize) && (j == CW'(1)) && (k == psize);

  // compare-exchange
  logic [31:0] ea, eb;
  logic        up;
  assign pad_a = (i >= fill_count) && !written[i[AW-1:0]];
  assign pad_b = (l >= fill_count) && !written[l[AW-1:0]];
  assign ea = pad_a ? pad_val : rdata_a;
  assign eb = pad_b ? pad_val : rdata_b;
  assign up = (((i & k) == '0) == ascending);
  assign swap = up ? (order_key(va) > order_key(vb)) : (order_key(va) < order_key(vb));

  always_ff @(posedge clk) begin
    if (state == ST_CMP) begin
      va <= ea;
      vb <= eb;
    end
  end
  assign wa = swap ? vb : va;
  assign wb = swap ? va : vb;

  logic out_rd;      // issue a read for out_idx this cycle
  logic out_rd_q;
  logic out_take;
  assign out_take = ob_valid && m_axis_tready;
  assign out_rd = (state == ST_OUT) && (out_idx < fill_count) && !out_rd_q &&
                  (!ob_valid || out_take);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (s_axis_tvalid && s_axis_tlast) state_next = ST_READ;
      ST_READ:  state_next = ST_CMP;
      ST_CMP:   state_next = ST_WRITE;
      ST_WRITE: state_next = last_pair ? ST_OUT : ST_READ;
      ST_OUT:   if (!ob_valid && !out_rd_q && out_idx == fill_count) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state == ST_LOAD);
    we_a = 1'b0;
    we_b = 1'b0;
    addr_a = i[AW-1:0];
    addr_b = l[AW-1:0];
    wdata_a = wa;
    wdata_b = wb;
    case (state)
      ST_LOAD: begin
        addr_a  = fill_count[AW-1:0];
        wdata_a = s_axis_tdata;
        we_a    = s_axis_tvalid && (fill_count < CW'(ROW_CAPACITY));
      end
      ST_WRITE: begin
        // pad entries too: a real value can pass through a pad slot
        we_a = 1'b1;
        we_b = 1'b1;
      end
      ST_OUT: begin
        addr_a = out_idx[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      fill_count    <= '0;
      overflow_seen <= 1'b0;
      out_idx       <= '0;
      out_rd_q      <= 1'b0;
      ob_valid      <= 1'b0;
    end else begin
      state    <= state_next;
      out_rd_q <= out_rd;
      case (state)
        ST_LOAD: begin
          if (s_axis_tvalid) begin
            if (fill_count < CW'(ROW_CAPACITY)) begin
              fill_count <= fill_count + CW'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          k <= CW'(2);
          j <= CW'(1);
          i <= '0;
          out_idx <= '0;
          psize <= CW'(MIN_ROW);
          written <= '0;
        end
        ST_READ: begin
          // grow padded size, one doubling per read, until it covers the row
          if (psize < fill_count) begin
            psize <= psize << 1;
          end
        end
        ST_WRITE: begin
          written <= written | (DEPTH'(1) << i[AW-1:0]) | (DEPTH'(1) << l[AW-1:0]);
          if (i_step < psize) begin
            i <= i_step;
          end else begin
            i <= '0;
            if (j == CW'(1)) begin
              k <= k << 1;
              j <= k;
            end else begin
              j <= j >> 1;
            end
          end
        end
        ST_OUT: begin
          if (out_rd) begin
            out_idx <= out_idx + CW'(1);
          end
          if (out_take) begin
            ob_valid <= 1'b0;
          end
          if (out_rd_q) begin
            ob_valid <= 1'b1;
            ob_data  <= rdata_a;
            ob_last  <= (out_idx == fill_count);
          end
          if (state_next == ST_LOAD) begin
            fill_count    <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = ob_valid;
  assign m_axis_tdata  = ob_data;
  assign m_axis_tlast  = ob_last;
  assign m_axis_tuser  = overflow_seen;

endmodule

>>> rtl/core/bfs_ram.sv
// ---------------------------------------------------------------------------
// bfs_ram : row store
// Two-port synchronous RAM with registered reads.
// ---------------------------------------------------------------------------
module bfs_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we_a,
  input  logic [AW-1:0] addr_a,
  input  logic [31:0]   wdata_a,
  output logic [31:0]   rdata_a,
  input  logic          we_b,
  input  logic [AW-1:0] addr_b,
  input  logic [31:0]   wdata_b,
  output logic [31:0]   rdata_b
);

  logic [31:0] mem [DEPTH];

  // both ports in one process; the sequencer never writes one entry from both ports at once
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem[addr_a] <= wdata_a;
    end
    if (we_b) begin
      mem[addr_b] <= wdata_b;
    end
    rdata_a <= mem[addr_a];
    rdata_b <= mem[addr_b];
  end

endmodule

>>> tb/bitonic_float_sorter_tb.sv
// ---------------------------------------------------------------------------
// bitonic_float_sorter_tb : self-checking bench for the bitonic float sorter
// Rows of float bit patterns go in over s_axis. Each accepted transaction
// feeds a software sort of the row, whose output is queued. Every m_axis
// transaction is compared field by field with the head of that queue.
// Random idling and stalls on both sides, a long output hold-off, and
// direction changes over APB between rows.
// ---------------------------------------------------------------------------
module bitonic_float_sorter_tb
  import bfs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_CAP = 64;
  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam logic [31:0] NEG_INF = 32'hFF80_0000;

  typedef struct packed {
    logic [31:0] value;
    logic        final_res;
    logic        overflow;
  } sorted_item_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] value
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] sorted_value
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;   // [0] overflow
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bitonic_float_sorter #(.ROW_CAPACITY(ROW_CAP)) dut (.*);

  // sorter state as seen from outside
  logic [31:0]  row_vals[ROW_CAP];
  int           row_fill;
  bit           row_dropped;
  bit           sort_up;
  logic [31:0]  work[2*ROW_CAP];
  sorted_item_t sorted_q[$];

  int  mismatches;
  int  src_idle_pct;
  int  snk_stall_pct;
  bit  hold_req;
  int  hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // generous limit: well above the slowest correct run
  initial begin
    #20ms;
    $display("bitonic_float_sorter test failed");
    $finish;
  end

  function automatic logic [31:0] float_rank(logic [31:0] bits);
    return bits[31] ? ~bits : {1'b1, bits[30:0]};
  endfunction

  // sort the closed row and queue its results
  task automatic sort_closed_row();
    int n;
    int p;
    int k;
    int j;
    int l;
    bit up;
    logic [31:0] t;
    sorted_item_t r;
    n = row_fill;
    p = 8;
    while (p < n) p = p * 2;
    for (int i = 0; i < p; i++)
      work[i] = (i < n) ? row_vals[i] : (sort_up ? PAD_POS_MAX : PAD_NEG_MAX);
    for (k = 2; k <= p; k = k * 2) begin
      for (j = k / 2; j > 0; j = j / 2) begin
        for (int i = 0; i < p; i++) begin
          l = i ^ j;
          if (l > i && l < p) begin
            up = (((i & k) == 0) == sort_up);
            if ((up && float_rank(work[i]) > float_rank(work[l])) ||
                (!up && float_rank(work[i]) < float_rank(work[l]))) begin
              t = work[i];
              work[i] = work[l];
              work[l] = t;
            end
          end
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r.value = work[i];
      r.final_res = (i == n - 1);
      r.overflow = row_dropped;
      sorted_q.push_back(r);
    end
    row_fill = 0;
    row_dropped = 0;
  endtask

  task automatic take_value(logic [31:0] v, bit last);
    if (row_fill < ROW_CAP) begin
      row_vals[row_fill] = v;
      row_fill++;
    end else begin
      row_dropped = 1;
    end
    if (last) sort_closed_row();
  endtask

  // one s_axis transaction, with random idling ahead of it;
  // tvalid stays high until the next idle cycle or wait_drained
  task automatic send_value(logic [31:0] v, bit last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    take_value(v, last);
  endtask

  task automatic send_row(int len);
    for (int i = 0; i < len; i++) send_value(pick_value(), i == len - 1);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return {1'($urandom_range(1)), 31'h0};
      1: return $urandom_range(1) ? PAD_POS_MAX : PAD_NEG_MAX;
      2: return $urandom_range(1) ? POS_INF : NEG_INF;
      3: return {$urandom_range(1) ? 1'b1 : 1'b0, 8'd127, 23'($urandom_range(7))};
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // APB write: setup then access, upper bits random (only bit 0 is kept)
  task automatic set_direction(bit up);
    wait_drained();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_ASCENDING;
    pwdata  <= {31'($urandom), 1'b0} | 32'(up);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sort_up = up;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // output side: check each accepted transaction, then pick next tready
  always @(posedge clk) begin
    sorted_item_t e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sorted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h last=%b ovf=%b",
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end else begin
          e = sorted_q.pop_front();
          if (e.value !== m_axis_tdata || e.final_res !== m_axis_tlast ||
              e.overflow !== m_axis_tuser[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h/%b/%b got %h/%b/%b", e.value,
                       e.final_res, e.overflow, m_axis_tdata, m_axis_tlast,
                       m_axis_tuser);
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // long output hold-off, counted here
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
  end

  // -- tests ----------------------------------------------------------------

  // extremes, signed zeros, single-entry row, non-power-of-two lengths
  task automatic test_directed();
    logic [31:0] ext[8] = '{32'h0, 32'h8000_0000, PAD_POS_MAX, PAD_NEG_MAX,
                            POS_INF, NEG_INF, 32'h3F80_0000, 32'hBF80_0000};
    send_value(32'h4049_0FDB, 1);
    foreach (ext[i]) send_value(ext[i], i == 7);
    // +inf in a short ascending row falls behind the pads
    send_value(POS_INF, 0);
    send_value(32'h8000_0000, 0);
    send_value(32'h0, 0);
    send_value(32'hFFFF_FFFF, 0);
    send_value(32'h0000_0001, 1);
    for (int i = 0; i < 9; i++) send_value(32'h8000_0000 + i, i == 8);
  endtask

  task automatic test_descending();
    set_direction(0);
    send_value(NEG_INF, 0);
    send_value(32'h0, 0);
    send_value(32'h8000_0000, 0);
    send_value(PAD_POS_MAX, 0);
    send_value(32'h7FFF_FFFF, 0);
    send_value(32'h1234_5678, 1);
    set_direction(1);
  endtask

  // row beyond capacity: excess dropped, overflow flagged
  task automatic test_overflow();
    send_row(ROW_CAP + 1);
  endtask

  // random rows, mostly short, with idling in several phases
  task automatic test_random_rows();
    int done;
    int len;
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = (ph == 1) ? 55 : (ph == 3) ? 28 : 0;
      snk_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 28 : 0;
      set_direction(ph[0] ? 1'b0 : 1'b1);
      done = 0;
      while (done < 4) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(10, 17) : $urandom_range(1, 9);
        send_row(len);
        done += len;
      end
    end
    src_idle_pct  = 0;
    snk_stall_pct = 0;
  endtask

  // output held off while rows keep coming: input must stall
  task automatic test_backpressure();
    hold_req = 1;
    send_row(6);
    send_row(8);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    row_fill = 0;
    row_dropped = 0;
    sort_up = 1;
    mismatches = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_descending();
    test_overflow();
    test_backpressure();
    test_random_rows();

    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && sorted_q.size() == 0) begin
      $display("bitonic_float_sorter test passed");
    end else begin
      $display("bitonic_float_sorter test failed");
    end
    $finish;
  end

endmodule
